### hw/rtl/hlxd_pkg.sv
// shared types and constants for the sync header / length / xor deframer
// no dependencies; imported by every module of the block

package hlxd_pkg;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 32;
   localparam int WORD_BYTES  = WORD_W / BYTE_W;
   localparam int CSR_INDEX_W = 1;

   // payload bytes kept for the result word, never more than fit in it
   localparam int KEPT_BYTES = 4;
   localparam int KEPT_LIMIT = (KEPT_BYTES < WORD_BYTES) ? KEPT_BYTES : WORD_BYTES;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // register reset values
   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_FIRST  = 1'b0,
      CSR_SYNC_SECOND = 1'b1
   } csr_index_type;

   // parser phases
   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_SECOND = 3'd1,
      PH_ID     = 3'd2,
      PH_LEN    = 3'd3,
      PH_DATA   = 3'd4,
      PH_CHECK  = 3'd5
   } phase_type;

   // one classified byte, as queued from front to back
   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              is_first;
      logic              is_second;
   } entry_type;

endpackage

### hw/rtl/header_length_xor_deframer.sv
// top level of the sync header / length / xor deframer
// depends on hlxd_pkg, hlxd_front, hlxd_queue and hlxd_back

// Takes one received byte per cycle on the req channel and sustains that rate
// while rsp is not stalled. Each byte is classified against the two sync
// registers on transfer and written into a short queue (QUEUE_DEPTH entries);
// the parser behind it consumes one queued byte per cycle, so req_stall rises
// only once the queue has filled behind a stalled result. A validated frame
// is loaded into the result register when the parser pops its check byte;
// a failed check is dropped without a result. The sync registers are written
// through the csr port and should change only while the block is idle.

module header_length_xor_deframer #(
   parameter int QUEUE_DEPTH = hlxd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [hlxd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hlxd_pkg::BYTE_W-1:0]      csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [hlxd_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [hlxd_pkg::BYTE_W-1:0]      rsp_frame_id,
   output logic [hlxd_pkg::BYTE_W-1:0]      rsp_payload_length,
   output logic [hlxd_pkg::WORD_W-1:0]      rsp_payload_word
);
   import hlxd_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   logic      pop_valid;
   entry_type pop_entry;

   // classification and input transfer
   hlxd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   // decoupling queue
   hlxd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // frame parser and result register
   hlxd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_entry          (pop_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_id       (rsp_frame_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_word   (rsp_payload_word)
   );

endmodule

### hw/rtl/hlxd_front.sv
// front part: sync registers, byte transfer and sync classification
// depends on hlxd_pkg

module hlxd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [hlxd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hlxd_pkg::BYTE_W-1:0]   csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hlxd_pkg::BYTE_W-1:0]   req_rx_byte,
   input  logic                          queue_full,
   output logic                          push,
   output hlxd_pkg::entry_type           push_entry
);
   import hlxd_pkg::*;

   logic [BYTE_W-1:0] sync_first_ff;
   logic [BYTE_W-1:0] sync_first_in;
   logic [BYTE_W-1:0] sync_second_ff;
   logic [BYTE_W-1:0] sync_second_in;

   // configuration writes
   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SYNC_FIRST:  sync_first_in  = csr_write_data;
            CSR_SYNC_SECOND: sync_second_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
      end
   end

   // input transfer goes straight into the queue
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // classify against both sync bytes
   always_comb begin
      push_entry.rx_byte   = req_rx_byte;
      push_entry.is_first  = (req_rx_byte == sync_first_ff);
      push_entry.is_second = (req_rx_byte == sync_second_ff);
   end

endmodule

### hw/rtl/hlxd_queue.sv
// short register queue between front and back
// depends on hlxd_pkg for the entry type

module hlxd_queue #(
   parameter int DEPTH = hlxd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hlxd_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output hlxd_pkg::entry_type pop_entry
);
   import hlxd_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DEPTH);

   entry_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;

   assign full      = (count_ff == COUNT_MAX);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop && pop_valid) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop && pop_valid})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/hlxd_back.sv
// back part: frame parser state machine, xor check and result register
// depends on hlxd_pkg

module hlxd_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   input  hlxd_pkg::entry_type            pop_entry,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hlxd_pkg::BYTE_W-1:0]    rsp_frame_id,
   output logic [hlxd_pkg::BYTE_W-1:0]    rsp_payload_length,
   output logic [hlxd_pkg::WORD_W-1:0]    rsp_payload_word
);
   import hlxd_pkg::*;

   phase_type         phase_ff;
   phase_type         phase_in;
   logic [BYTE_W-1:0] held_id_ff;
   logic [BYTE_W-1:0] held_id_in;
   logic [BYTE_W-1:0] held_length_ff;
   logic [BYTE_W-1:0] held_length_in;
   logic [BYTE_W-1:0] bytes_taken_ff;
   logic [BYTE_W-1:0] bytes_taken_in;
   logic [BYTE_W-1:0] running_xor_ff;
   logic [BYTE_W-1:0] running_xor_in;
   logic [WORD_W-1:0] kept_ff;
   logic [WORD_W-1:0] kept_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_id_ff;
   logic [BYTE_W-1:0] rsp_length_ff;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              emit;
   logic [BYTE_W-1:0] b;
   logic [BYTE_W-1:0] taken_next;

   // take a byte whenever the result register can hold what it may cause
   assign pop        = pop_valid && !(rsp_valid_ff && rsp_stall);
   assign b          = pop_entry.rx_byte;
   assign taken_next = bytes_taken_ff + 1'b1;

   // next state of the parser
   always_comb begin
      phase_in       = phase_ff;
      held_id_in     = held_id_ff;
      held_length_in = held_length_ff;
      bytes_taken_in = bytes_taken_ff;
      running_xor_in = running_xor_ff;
      kept_in        = kept_ff;
      emit           = 1'b0;
      if (pop) begin
         unique case (phase_ff)
            PH_SECOND: begin
               if (pop_entry.is_second) begin
                  running_xor_in = running_xor_ff ^ b;
                  phase_in       = PH_ID;
               end else if (pop_entry.is_first) begin
                  // a repeated first sync byte restarts the second-byte wait
                  running_xor_in = b;
               end else begin
                  running_xor_in = '0;
                  phase_in       = PH_HUNT;
               end
            end
            PH_ID: begin
               held_id_in     = b;
               running_xor_in = running_xor_ff ^ b;
               phase_in       = PH_LEN;
            end
            PH_LEN: begin
               held_length_in = b;
               running_xor_in = running_xor_ff ^ b;
               bytes_taken_in = '0;
               kept_in        = '0;
               phase_in       = (b == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
               for (int i = 0; i < KEPT_LIMIT; i++) begin
                  if (bytes_taken_ff == BYTE_W'(i)) begin
                     kept_in[i*BYTE_W +: BYTE_W] = b;
                  end
               end
               running_xor_in = running_xor_ff ^ b;
               bytes_taken_in = taken_next;
               if (taken_next >= held_length_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               emit           = (b == running_xor_ff);
               running_xor_in = '0;
               phase_in       = PH_HUNT;
            end
            default: begin
               // hunting for the first sync byte
               if (pop_entry.is_first) begin
                  running_xor_in = b;
                  phase_in       = PH_SECOND;
               end else begin
                  running_xor_in = '0;
                  phase_in       = PH_HUNT;
               end
            end
         endcase
      end
   end

   // result register valid flag
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         running_xor_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         running_xor_ff <= running_xor_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // frame fields and result payload
   always_ff @(posedge clock) begin
      held_id_ff     <= held_id_in;
      held_length_ff <= held_length_in;
      bytes_taken_ff <= bytes_taken_in;
      kept_ff        <= kept_in;
      if (emit) begin
         rsp_id_ff     <= held_id_ff;
         rsp_length_ff <= held_length_ff;
         rsp_word_ff   <= kept_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_id       = rsp_id_ff;
   assign rsp_payload_length = rsp_length_ff;
   assign rsp_payload_word   = rsp_word_ff;

endmodule
